// ===== design/acc_alu_pkg.sv =====
// Package with widths, request codes, register codes and operation codes of the accumulator ALU.
`default_nettype none
package acc_alu_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_DRIVE = 2'd1;
  localparam logic [1:0] REQ_JUMP  = 2'd2;
  localparam logic [1:0] REQ_NOP   = 2'd3;

  localparam logic [7:0] CODE_A   = 8'd3;
  localparam logic [7:0] CODE_B   = 8'd4;
  localparam logic [7:0] CODE_ACC = 8'd5;
  localparam logic [7:0] CODE_C   = 8'd14;
  localparam logic [7:0] CODE_D   = 8'd15;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_EQ  = 3'd5;
  localparam logic [2:0] OP_AND = 3'd6;

  typedef logic [DATA_WIDTH-1:0] word_t;

endpackage
`default_nettype wire

// ===== design/accumulator_alu_with_registers_core.sv =====
// Accumulator ALU with registers A, B, C, D, flags and a shared iterative multiply/divide unit.
// A transaction that needs no multiply, divide or modulo shows its result in the cycle after
// acceptance; a load of A or B with multiply, divide or modulo shows it when the iteration ends.
// Short transactions are taken one per cycle while out_ready is high; a long one holds off new
// ones until it ends; the shared adder retires one product or quotient bit per cycle.
// Reset is synchronous and clears A, B, C, D, the accumulator, both flags and all control state.
`default_nettype none
module accumulator_alu_with_registers_core (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [1:0]                         req_type,
  input  wire logic [7:0]                         operand_code,
  input  wire logic [acc_alu_pkg::DATA_WIDTH-1:0] bus_data_in,
  input  wire logic [2:0]                         alu_op,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    bus_drive,
  output logic [acc_alu_pkg::DATA_WIDTH-1:0]      bus_data_out,
  output logic                                    jump_taken,
  output logic [7:0]                              jump_target,
  output logic                                    zero_out,
  output logic                                    negative_out
);

  localparam int W = acc_alu_pkg::DATA_WIDTH;
  localparam logic S_IDLE = 1'b0;
  localparam logic S_ITER = 1'b1;

  logic                           state;
  logic [2:0]                     op;
  logic [acc_alu_pkg::CNT_W-1:0]  cnt;
  acc_alu_pkg::word_t             reg_a;
  acc_alu_pkg::word_t             reg_b;
  acc_alu_pkg::word_t             reg_c;
  acc_alu_pkg::word_t             reg_d;
  acc_alu_pkg::word_t             acc;
  logic                           zf;
  logic                           nf;
  acc_alu_pkg::word_t             work_acc;
  acc_alu_pkg::word_t             work_x;
  acc_alu_pkg::word_t             work_y;

  acc_alu_pkg::word_t             na;
  acc_alu_pkg::word_t             nb;
  logic [W:0]                     ux;
  logic [W:0]                     uy;
  logic                           usub;
  logic [W+1:0]                   usum;
  logic                           ge;
  acc_alu_pkg::word_t             work_acc_next;
  acc_alu_pkg::word_t             work_x_next;
  acc_alu_pkg::word_t             work_y_next;
  acc_alu_pkg::word_t             iter_result;
  acc_alu_pkg::word_t             simple_result;
  logic                           accept;
  logic                           load_ab;
  logic                           long_op;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign load_ab  = (req_type == acc_alu_pkg::REQ_LOAD) &&
                    ((operand_code == acc_alu_pkg::CODE_A) ||
                     (operand_code == acc_alu_pkg::CODE_B));
  assign long_op  = (alu_op == acc_alu_pkg::OP_MUL) || (alu_op == acc_alu_pkg::OP_DIV) ||
                    (alu_op == acc_alu_pkg::OP_MOD);

  assign na = (operand_code == acc_alu_pkg::CODE_A) ? bus_data_in : reg_a;
  assign nb = (operand_code == acc_alu_pkg::CODE_B) ? bus_data_in : reg_b;

  always_comb begin
    unique case (state)
      S_IDLE: begin
        ux   = {1'b0, na};
        uy   = {1'b0, nb};
        usub = (alu_op == acc_alu_pkg::OP_SUB);
      end
      S_ITER: begin
        if (op == acc_alu_pkg::OP_MUL) begin
          ux   = {1'b0, work_acc};
          uy   = {1'b0, work_x};
          usub = 1'b0;
        end else begin
          ux   = {work_acc, work_x[W-1]};
          uy   = {1'b0, reg_b};
          usub = 1'b1;
        end
      end
      default: begin
        ux   = '0;
        uy   = '0;
        usub = 1'b0;
      end
    endcase
  end

  assign usum = {1'b0, ux} + {1'b0, (usub ? ~uy : uy)} + {{(W+1){1'b0}}, usub};
  assign ge   = usum[W+1];

  always_comb begin
    if (op == acc_alu_pkg::OP_MUL) begin
      work_acc_next = work_y[0] ? usum[W-1:0] : work_acc;
      work_x_next   = {work_x[W-2:0], 1'b0};
      work_y_next   = {1'b0, work_y[W-1:1]};
      iter_result   = work_acc_next;
    end else begin
      work_acc_next = ge ? usum[W-1:0] : ux[W-1:0];
      work_x_next   = {work_x[W-2:0], ge};
      work_y_next   = work_y;
      iter_result   = (op == acc_alu_pkg::OP_DIV) ? work_x_next : work_acc_next;
    end
  end

  always_comb begin
    unique case (alu_op)
      acc_alu_pkg::OP_EQ:  simple_result = {{(W-1){1'b0}}, (na == nb)};
      acc_alu_pkg::OP_AND: simple_result = na & nb;
      default:             simple_result = usum[W-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      op        <= acc_alu_pkg::OP_ADD;
      cnt       <= '0;
      reg_a     <= '0;
      reg_b     <= '0;
      reg_c     <= '0;
      reg_d     <= '0;
      acc       <= '0;
      zf        <= 1'b0;
      nf        <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_ITER) begin
        work_acc <= work_acc_next;
        work_x   <= work_x_next;
        work_y   <= work_y_next;
        cnt      <= cnt - 1'b1;
        if (cnt == '0) begin
          state        <= S_IDLE;
          acc          <= iter_result;
          zf           <= (iter_result == '0);
          nf           <= iter_result[W-1];
          out_valid    <= 1'b1;
          bus_drive    <= 1'b0;
          bus_data_out <= '0;
          jump_taken   <= 1'b0;
          jump_target  <= '0;
          zero_out     <= (iter_result == '0);
          negative_out <= iter_result[W-1];
        end
      end else if (accept) begin
        bus_drive    <= 1'b0;
        bus_data_out <= '0;
        jump_taken   <= 1'b0;
        jump_target  <= '0;
        zero_out     <= zf;
        negative_out <= nf;
        unique case (req_type)
          acc_alu_pkg::REQ_LOAD: begin
            priority if (operand_code == acc_alu_pkg::CODE_A) begin
              reg_a <= bus_data_in;
            end else if (operand_code == acc_alu_pkg::CODE_B) begin
              reg_b <= bus_data_in;
            end else if (operand_code == acc_alu_pkg::CODE_C) begin
              reg_c <= bus_data_in;
            end else if (operand_code == acc_alu_pkg::CODE_D) begin
              reg_d <= bus_data_in;
            end
          end
          acc_alu_pkg::REQ_DRIVE: begin
            priority if (operand_code == acc_alu_pkg::CODE_ACC) begin
              bus_drive    <= 1'b1;
              bus_data_out <= acc;
            end else if (operand_code == acc_alu_pkg::CODE_C) begin
              bus_drive    <= 1'b1;
              bus_data_out <= reg_c;
            end else if (operand_code == acc_alu_pkg::CODE_D) begin
              bus_drive    <= 1'b1;
              bus_data_out <= reg_d;
            end
          end
          acc_alu_pkg::REQ_JUMP: begin
            if (zf) begin
              jump_taken  <= 1'b1;
              jump_target <= operand_code;
            end
          end
          default: begin
          end
        endcase
        if (load_ab && long_op) begin
          state    <= S_ITER;
          op       <= alu_op;
          cnt      <= acc_alu_pkg::CNT_W'(W - 1);
          work_acc <= '0;
          work_x   <= na;
          work_y   <= nb;
        end else begin
          out_valid <= 1'b1;
          if (load_ab) begin
            acc          <= simple_result;
            zf           <= (simple_result == '0);
            nf           <= simple_result[W-1];
            zero_out     <= (simple_result == '0);
            negative_out <= simple_result[W-1];
          end
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_long_op_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && load_ab && (alu_op == acc_alu_pkg::OP_MUL)) |=> (state == S_ITER && !out_valid))
    else $error("multiply load did not start the iterative unit");

  a_iter_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_ITER && cnt == '0) |=> (state == S_IDLE && out_valid))
    else $error("iteration end did not deliver a result");

  a_no_drive_and_jump: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bus_drive && jump_taken))
    else $error("bus drive and jump in the same transaction");

  a_jump_target_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !jump_taken) |-> (jump_target == '0))
    else $error("jump target set without a jump");

  a_flags_match: assert property (@(posedge clk) disable iff (rst)
    (out_valid && state == S_IDLE && !(accept)) |-> (zero_out == zf && negative_out == nf))
    else $error("reported flags differ from flag registers");
`endif

endmodule
`default_nettype wire
